@@ rtl/mpbp_pkg.sv @@
package mpbp_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int BBM_W      = 2;
    localparam int CNT_W      = 6;
    localparam int IDX_W      = 5;

    localparam logic [CFG_ADDR_W-1:0] CFG_USED_BIT_MASK         = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_BYTES_MINUS_ONE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FILL_MASK             = 2'd2;

    localparam logic [DATA_W-1:0] RST_USED_BIT_MASK         = 32'hFFFF_FFFF;
    localparam logic [BBM_W-1:0]  RST_BLOCK_BYTES_MINUS_ONE = 2'd0;
    localparam logic [DATA_W-1:0] RST_FILL_MASK             = 32'h0000_00FF;

    localparam logic [BBM_W-1:0] BBM_8  = 2'd0;
    localparam logic [BBM_W-1:0] BBM_16 = 2'd1;
    localparam logic [BBM_W-1:0] BBM_24 = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] pixel;
        logic              last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [DATA_W-1:0] block;
        logic              end_of_stream;
        logic              last_of_run;
    } block_t;

    function automatic logic [DATA_W-1:0] block_mask(input logic [BBM_W-1:0] bbm);
        logic [DATA_W-1:0] m;
        case (bbm)
            BBM_8:   m = 32'h0000_00FF;
            BBM_16:  m = 32'h0000_FFFF;
            BBM_24:  m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/masked_pixel_bit_packer.sv @@
// first block: a pixel taken into the work stage register reaches the result stage register
// work stage: a pixel holds the work stage for a step per block it completes, and a closing
// step when bits remain after its last completed block or it completes none; a new pixel
// can be taken in the step that finishes the last, and result stalls hold the steps
// reset: aresetn is synchronous, active low; it restores the register defaults
// and empties the work and result stages
module masked_pixel_bit_packer #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mpbp_pkg::pixel_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mpbp_pkg::block_t                    m_data,
    input  logic                                cfg_wr_en,
    input  logic [mpbp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mpbp_pkg::DATA_W-1:0]         cfg_wdata
);

    localparam int W = mpbp_pkg::DATA_W;
    localparam logic [W-1:0] PIX_MASK = W'((33'h1 << PIXEL_BITS) - 33'h1);
    localparam logic [W-1:0] ONES = '1;

    // configuration
    logic [W-1:0]                  used_reg, used_next;
    logic [mpbp_pkg::BBM_W-1:0]    bbm_reg, bbm_next;
    logic [W-1:0]                  fill_reg, fill_next;
    logic                          cfg_restart;

    // derived from configuration
    logic [W-1:0]                  fill_eff_reg, fill_eff_next;
    logic [W-1:0]                  used_eff_next;
    logic [mpbp_pkg::CNT_W-1:0]    k_reg, k_next;
    logic [mpbp_pkg::CNT_W-1:0]    ucnt_reg, ucnt_next;
    logic [mpbp_pkg::IDX_W-1:0]    rank_reg [W];
    logic [mpbp_pkg::IDX_W-1:0]    rank_next [W];
    logic [mpbp_pkg::IDX_W-1:0]    urank [W];
    logic [mpbp_pkg::IDX_W-1:0]    src_reg [W];
    logic [mpbp_pkg::IDX_W-1:0]    src_next [W];
    logic [W-1:0]                  urev_reg, urev_next;

    // work stage
    logic                          work_valid_reg, work_valid_next;
    logic [W-1:0]                  rem_reg, rem_next;
    logic [mpbp_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          last_reg, last_next;
    logic [W-1:0]                  ext;

    // packing state, accumulator held in fill order
    logic [W-1:0]                  acc_reg, acc_next;
    logic [mpbp_pkg::IDX_W-1:0]    slot_reg, slot_next;

    // result stage
    logic                          m_valid_reg, m_valid_next;
    mpbp_pkg::block_t              m_data_reg, m_data_next;

    logic                          out_free, step, fill_empty, full, pix_done, emit;
    logic                          run_end;
    logic [mpbp_pkg::CNT_W-1:0]    avail, take, shamt, slot_sum, cnt_after;
    logic [W-1:0]                  acc_new, blk;
    logic                          s_accept;

    always_comb begin
        used_next   = used_reg;
        bbm_next    = bbm_reg;
        fill_next   = fill_reg;
        cfg_restart = 1'b0;
        if (!aresetn) begin
            used_next = mpbp_pkg::RST_USED_BIT_MASK;
            bbm_next  = mpbp_pkg::RST_BLOCK_BYTES_MINUS_ONE;
            fill_next = mpbp_pkg::RST_FILL_MASK;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mpbp_pkg::CFG_USED_BIT_MASK: begin
                    used_next   = cfg_wdata;
                    cfg_restart = 1'b1;
                end
                mpbp_pkg::CFG_BLOCK_BYTES_MINUS_ONE: begin
                    bbm_next    = cfg_wdata[mpbp_pkg::BBM_W-1:0];
                    cfg_restart = 1'b1;
                end
                mpbp_pkg::CFG_FILL_MASK: begin
                    fill_next   = cfg_wdata;
                    cfg_restart = 1'b1;
                end
                default: begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
    end

    // fill ranks for the deposit, source index of each taken pixel bit
    always_comb begin
        fill_eff_next = fill_next & mpbp_pkg::block_mask(bbm_next);
        used_eff_next = used_next & PIX_MASK;
        k_next        = mpbp_pkg::CNT_W'($countones(fill_eff_next));
        ucnt_next     = mpbp_pkg::CNT_W'($countones(used_eff_next));
        for (int p = 0; p < W; p++) begin
            rank_next[p] = mpbp_pkg::IDX_W'($countones(fill_eff_next & ((W'(1) << p) - W'(1))));
            urank[p]     = mpbp_pkg::IDX_W'($countones(used_eff_next & ((W'(1) << p) - W'(1))));
        end
        for (int t = 0; t < W; t++) begin
            src_next[t] = '0;
            for (int p = 0; p < W; p++) begin
                if (used_eff_next[p] && (urank[p] == mpbp_pkg::IDX_W'(t))) begin
                    src_next[t] = src_next[t] | mpbp_pkg::IDX_W'(p);
                end
            end
        end
        urev_next = ~(ONES >> ucnt_next);
    end

    // taken bits, first one at the top
    always_comb begin
        for (int t = 0; t < W; t++) begin
            ext[W-1-t] = s_data.pixel[src_reg[t]] & urev_reg[W-1-t];
        end
    end

    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        step       = work_valid_reg && out_free;
        fill_empty = (k_reg == '0);
        avail      = k_reg - {1'b0, slot_reg};
        full       = !fill_empty && (cnt_reg >= avail);
        take       = full ? avail : cnt_reg;
        shamt      = mpbp_pkg::CNT_W'(W) - k_reg + {1'b0, slot_reg};
        acc_new    = acc_reg | (rem_reg >> shamt);
        slot_sum   = {1'b0, slot_reg} + cnt_reg;
        cnt_after  = cnt_reg - take;
        pix_done   = fill_empty || !full || (cnt_after == '0);
        // no further block from this pixel after this step's block
        run_end    = !full || ((cnt_after < k_reg) && !(last_reg && (cnt_after != '0)));
        for (int p = 0; p < W; p++) begin
            blk[p] = fill_eff_reg[p] & acc_new[rank_reg[p]];
        end
        emit = 1'b0;
        if (!fill_empty) begin
            if (full) begin
                emit = 1'b1;
            end else begin
                emit = last_reg && (slot_sum != '0);
            end
        end
        s_ready  = !work_valid_reg || (step && pix_done);
        s_accept = s_valid && s_ready;
    end

    always_comb begin
        acc_next        = acc_reg;
        slot_next       = slot_reg;
        work_valid_next = work_valid_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (step) begin
            if (!fill_empty) begin
                if (full || last_reg) begin
                    acc_next  = '0;
                    slot_next = '0;
                end else begin
                    acc_next  = acc_new;
                    slot_next = slot_sum[mpbp_pkg::IDX_W-1:0];
                end
            end
            if (emit) begin
                m_valid_next                = 1'b1;
                m_data_next.block           = blk;
                m_data_next.end_of_stream   = last_reg && run_end;
                m_data_next.last_of_run     = run_end;
            end
            if (pix_done) begin
                work_valid_next = 1'b0;
            end else begin
                rem_next = rem_reg << take;
                cnt_next = cnt_after;
            end
        end

        if (s_accept) begin
            work_valid_next = 1'b1;
            rem_next        = ext;
            cnt_next        = ucnt_reg;
            last_next       = s_data.last_pixel;
        end

        if (cfg_restart) begin
            acc_next  = '0;
            slot_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        used_reg     <= used_next;
        bbm_reg      <= bbm_next;
        fill_reg     <= fill_next;
        fill_eff_reg <= fill_eff_next;
        k_reg        <= k_next;
        ucnt_reg     <= ucnt_next;
        urev_reg     <= urev_next;
        rank_reg     <= rank_next;
        src_reg      <= src_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        last_reg     <= last_next;
        m_data_reg   <= m_data_next;
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            acc_reg        <= '0;
            slot_reg       <= '0;
        end else begin
            work_valid_reg <= work_valid_next;
            m_valid_reg    <= m_valid_next;
            acc_reg        <= acc_next;
            slot_reg       <= slot_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/mpbp_checker.sv @@
module mpbp_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input mpbp_pkg::block_t                    m_data
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // final block of a stream closes its pixel's run
    a_eos_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.end_of_stream || m_data.last_of_run))
        else $error("end_of_stream without last_of_run");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a pixel taken during a stalled result still leaves the result in place
    a_accept_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && m_valid && !m_ready |=> m_valid)
        else $error("result lost on input transaction");

endmodule

bind masked_pixel_bit_packer mpbp_checker u_mpbp_checker (.*);
